// ===== hw/rtl/binary_grid_square_cover_check_assert.svh =====
// Assertion macros for the 2x2 square cover checker.
// Used by the top level only; expects signals named clk and arst_n in scope.
`ifndef BINARY_GRID_SQUARE_COVER_CHECK_ASSERT_SVH
`define BINARY_GRID_SQUARE_COVER_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BGSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bgsc: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BGSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bgsc: next-cycle check failed");
`else
`define BGSC_ASSERT_IMP(lbl, ante, cons)
`define BGSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/bgsc_pkg.sv =====
// Shared constants, codes and types of the 2x2 square cover checker.
// No dependencies; imported by every module of the block but bgsc_ram.
package bgsc_pkg;

	localparam int MAX_DIM    = 64;
	localparam int DIM_W      = 7;
	localparam int POS_W      = $clog2(MAX_DIM);
	localparam int CNT_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

	// Result kinds.
	localparam logic KIND_SQUARE  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// One accepted pixel together with its position in the image.
	typedef struct packed {
		logic             pixel;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             row0;
		logic             col0;
		logic             final_row;
		logic             end_row;
	} pix_item_t;

	// Line buffer word: pixel of the row and whether a square ended there.
	typedef struct packed {
		logic pix;
		logic sq;
	} ram_word_t;

	// Line buffer read request issued when a pixel is accepted.
	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] addr;
	} lookup_t;

	// One result item.
	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             fits;
		logic [CNT_W-1:0] count;
		logic             last;
	} out_item_t;

	// Up to two result items written into the output queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		out_item_t  first;
		out_item_t  second;
	} push_t;

endpackage

// ===== hw/rtl/binary_grid_square_cover_check.sv =====
// 2x2 square cover checker on a streamed binary image.
//
// Pixels enter one per beat on the s_ channel in row-major order, the pixel
// in s_tdata[0]. The image size comes from two registers written on the cfg
// channel: index 0 rows, index 1 cols, each clamped to 2..64. A write to
// either register abandons the image in progress.
// Whenever a pixel completes a 2x2 block of ones, a square beat leaves on the
// m_ channel with the 1-based top-left position (m_tuser = 0). After the last
// pixel of the image a verdict beat follows (m_tuser = 1, m_tlast = 1) with
// the fit flag and the square count; when fit is 0 the square beats of that
// image are to be discarded.
// A result beat is formed from the input stage, written into the output queue
// and presented from there. While the output queue has room,
// the block accepts one pixel every cycle; the single extra verdict beat per
// image is absorbed by a four-entry output queue.
// The previous image row lives in a 64 x 2 line buffer with one read and one
// write per pixel, so no clearing pass is needed after reset.
// Reset empties the queue, sets both dimensions to 64 and starts a new image.
// When the receiver stalls, results wait in the queue; once fewer than two
// entries are free, a pixel waits in the input stage and s_tready drops.
`include "binary_grid_square_cover_check_assert.svh"

module binary_grid_square_cover_check
	import bgsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [0] pixel, [7:1] zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,  // [5:0] square_row, [11:6] square_col,
	                                       // [12] fits, [24:13] square_count, [31:25] zero
	output logic                 m_tuser,  // [0] kind
	output logic                 m_tlast
);

	logic      valid_s1;
	logic      fire_s1;
	pix_item_t item_s1;
	lookup_t   lookup;
	logic      clear;
	logic      room;
	push_t     push;
	out_item_t out_item;

	// Configuration, raster position and input stage.
	bgsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_pixel  (s_tdata[0]),
		.fire_s1  (fire_s1),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.lookup   (lookup),
		.clear    (clear)
	);

	// Per-pixel evaluation against the line buffer.
	bgsc_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.valid_s1(valid_s1),
		.item_s1 (item_s1),
		.lookup  (lookup),
		.room    (room),
		.fire_s1 (fire_s1),
		.push    (push)
	);

	// Result queue in front of the master port.
	bgsc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_item (out_item)
	);

	// Output beat packing.
	assign m_tdata = {7'd0, out_item.count, out_item.fits, out_item.col, out_item.row};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;

	// Only the verdict closes an image.
	`BGSC_ASSERT_IMP(a_last_is_verdict, m_tvalid, m_tlast == m_tuser)
	// A verdict carries no square position.
	`BGSC_ASSERT_IMP(a_verdict_no_pos, m_tvalid && m_tuser == KIND_VERDICT, m_tdata[11:0] == '0)
	// A held input stage must block the slave port.
	`BGSC_ASSERT_IMP(a_stall_blocks_input, valid_s1 && !fire_s1, !s_tready)
	// A retired pixel with nothing new behind it empties the input stage.
	`BGSC_ASSERT_NXT(a_stage_drains, fire_s1 && !s_tvalid, !valid_s1)

endmodule

// ===== hw/rtl/bgsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgsc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bgsc_ctrl.sv =====
// Configuration registers, pixel position counters and the input stage.
// Depends on bgsc_pkg.
module bgsc_ctrl
	import bgsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_pixel,
	input  logic                 fire_s1,
	output logic                 valid_s1,
	output pix_item_t            item_s1,
	output lookup_t              lookup,
	output logic                 clear
);

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] last_row;
	logic [POS_W-1:0] last_col;
	logic             accept;
	logic             final_row;
	logic             end_row;

	// Clamp a dimension to 2..MAX_DIM and return it minus one.
	function automatic logic [POS_W-1:0] dim_last(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] t;
		if (v < DIM_W'(2)) begin
			t = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			t = DIM_W'(MAX_DIM - 1);
		end else begin
			t = v - DIM_W'(1);
		end
		return t[POS_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign clear     = cfg_valid && (cfg_index == REG_ROWS || cfg_index == REG_COLS);

	assign s_tready  = !valid_s1 || fire_s1;
	assign accept    = s_tvalid && s_tready;
	assign last_row  = dim_last(rows_q);
	assign last_col  = dim_last(cols_q);
	assign final_row = (row_q == last_row);
	assign end_row   = (col_q == last_col);

	// The line buffer is read for the column of the pixel being accepted.
	assign lookup.en   = accept;
	assign lookup.addr = col_q;

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(MAX_DIM);
			cols_q <= DIM_W'(MAX_DIM);
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= cfg_data;
			end else if (cfg_index == REG_COLS) begin
				cols_q <= cfg_data;
			end
		end
	end

	// Raster position of the next pixel; restarts at image end or on a dimension write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (clear) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= final_row ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.pixel     <= s_pixel;
			item_s1.row       <= row_q;
			item_s1.col       <= col_q;
			item_s1.row0      <= (row_q == '0);
			item_s1.col0      <= (col_q == '0);
			item_s1.final_row <= final_row;
			item_s1.end_row   <= end_row;
		end
	end

endmodule

// ===== hw/rtl/bgsc_eval.sv =====
// Square detection, coverage check and verdict; one pixel per cycle given room.
// Depends on bgsc_pkg and bgsc_ram (line buffer of the previous row).
module bgsc_eval
	import bgsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      clear,
	input  logic      valid_s1,
	input  pix_item_t item_s1,
	input  lookup_t   lookup,
	input  logic      room,
	output logic      fire_s1,
	output push_t     push
);

	ram_word_t        up_cur;
	ram_word_t        up_prev_q;
	ram_word_t        wr_word;
	logic [$bits(ram_word_t)-1:0] rd_raw;
	logic             left_q;
	logic             sq_prev_q;
	logic             mis_q;
	logic [CNT_W-1:0] cnt_q;
	logic             has_up;
	logic             has_left;
	logic             sq;
	logic             cov_left;
	logic             mis_left;
	logic             mis_end;
	logic             mis_next;
	logic [CNT_W-1:0] cnt_next;
	logic             verdict;
	out_item_t        sq_item;
	out_item_t        vd_item;

	// Line buffer: per column, the pixel of the row above and whether a square
	// ended there. Read when the pixel is accepted, rewritten when it retires.
	bgsc_ram #(
		.WIDTH($bits(ram_word_t)),
		.DEPTH(MAX_DIM)
	) u_line (
		.clk    (clk),
		.wr_en  (fire_s1),
		.wr_addr(item_s1.col),
		.wr_data(wr_word),
		.rd_en  (lookup.en),
		.rd_addr(lookup.addr),
		.rd_data(rd_raw)
	);

	assign up_cur  = rd_raw;
	assign fire_s1 = valid_s1 && room;

	// A square needs the two pixels above, the left pixel and this one.
	assign has_up   = !item_s1.row0;
	assign has_left = !item_s1.col0;
	assign sq       = has_up && has_left && up_prev_q.pix && up_cur.pix && left_q
	                  && item_s1.pixel;

	// Coverage of the column to the left in the row above is final now.
	assign cov_left = up_prev_q.sq | up_cur.sq | sq_prev_q | sq;
	assign mis_left = has_left && ((has_up && (up_prev_q.pix != cov_left)) ||
	                  (item_s1.final_row && (left_q != (sq_prev_q | sq))));

	// At the end of a row this column is final too.
	assign mis_end  = item_s1.end_row && ((has_up && (up_cur.pix != (up_cur.sq | sq))) ||
	                  (item_s1.final_row && (item_s1.pixel != sq)));

	assign mis_next = mis_q | mis_left | mis_end;
	assign cnt_next = (sq && cnt_q != COUNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
	assign verdict  = item_s1.end_row && item_s1.final_row;

	assign wr_word.pix = item_s1.pixel;
	assign wr_word.sq  = sq;

	// Result items.
	always_comb begin
		sq_item.kind  = KIND_SQUARE;
		sq_item.row   = item_s1.row;
		sq_item.col   = item_s1.col;
		sq_item.fits  = 1'b0;
		sq_item.count = '0;
		sq_item.last  = 1'b0;

		vd_item.kind  = KIND_VERDICT;
		vd_item.row   = '0;
		vd_item.col   = '0;
		vd_item.fits  = !mis_next;
		vd_item.count = cnt_next;
		vd_item.last  = 1'b1;

		push.n      = fire_s1 ? (2'(sq) + 2'(verdict)) : 2'd0;
		push.first  = sq ? sq_item : vd_item;
		push.second = vd_item;
	end

	// Neighbor and image state, advanced once per retired pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= 1'b0;
			sq_prev_q <= 1'b0;
			mis_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (clear) begin
			left_q    <= 1'b0;
			sq_prev_q <= 1'b0;
			mis_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (fire_s1) begin
			left_q    <= item_s1.end_row ? 1'b0 : item_s1.pixel;
			sq_prev_q <= sq;
			mis_q     <= verdict ? 1'b0 : mis_next;
			cnt_q     <= verdict ? '0 : cnt_next;
		end
	end

	// Above-row word of this column becomes the upper-left word for the next pixel.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			up_prev_q <= up_cur;
		end
	end

endmodule

// ===== hw/rtl/bgsc_outq.sv =====
// Output queue: takes up to two result items a cycle, sends one per beat.
// Depends on bgsc_pkg.
module bgsc_outq
	import bgsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	out_item_t          mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_q;
	logic [OUTQ_AW-1:0] rd_q;
	logic [OUTQ_AW:0]   level_q;
	logic               pop;

	assign out_valid = (level_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (level_q <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + OUTQ_AW'(push.n);
			rd_q    <= rd_q + OUTQ_AW'(pop);
			level_q <= level_q + (OUTQ_AW+1)'(push.n) - (OUTQ_AW+1)'(pop);
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + OUTQ_AW'(1)] <= push.second;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the 2x2 square cover checker.
// Depends on bgsc_pkg and binary_grid_square_cover_check; holds its own predictor and stimulus.
`timescale 1ns / 100ps

module tb
	import bgsc_pkg::*;
;

	// Index codes that map to no register; writes to them change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef enum {IMG_SQUARES, IMG_SQUARES_FLIP, IMG_NOISE, IMG_BLANK, IMG_FULL} image_style_t;

	// Tracks coverage of the image in progress and holds the results still to come.
	class square_cover_tracker;
		bit [DIM_W-1:0] rows_reg;
		bit [DIM_W-1:0] cols_reg;
		bit             prev_pix [MAX_DIM];
		bit             prev_cov [MAX_DIM];
		bit             cur_cov  [MAX_DIM];
		bit             left_pix;
		int unsigned    row_pos;
		int unsigned    col_pos;
		bit             mismatch;
		int unsigned    squares;
		out_item_t      awaited_results [$];
		int             errors;

		function new();
			rows_reg = DIM_W'(MAX_DIM);
			cols_reg = DIM_W'(MAX_DIM);
			errors = 0;
			clear_image();
		endfunction

		function void clear_image();
			foreach (prev_pix[k]) begin
				prev_pix[k] = 1'b0;
				prev_cov[k] = 1'b0;
				cur_cov[k] = 1'b0;
			end
			left_pix = 1'b0;
			row_pos = 0;
			col_pos = 0;
			mismatch = 1'b0;
			squares = 0;
		endfunction

		function int unsigned clamp_dim(bit [DIM_W-1:0] v);
			if (v < 2)
				return 2;
			if (v > MAX_DIM)
				return MAX_DIM;
			return 32'(v);
		endfunction

		// Append one result beat to the list of beats still to come.
		function void queue_result(out_item_t beat);
			awaited_results = {awaited_results, beat};
		endfunction

		// Column j of the row above is finished: check it, then move the current row in.
		function void retire_col(int unsigned j, bit cur, bit check_prev, bit final_row);
			if (check_prev && prev_pix[j] != prev_cov[j])
				mismatch = 1'b1;
			if (final_row && cur != cur_cov[j])
				mismatch = 1'b1;
			prev_pix[j] = cur;
			prev_cov[j] = cur_cov[j];
			cur_cov[j] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
			if (idx == REG_ROWS) begin
				rows_reg = val;
				clear_image();
			end else if (idx == REG_COLS) begin
				cols_reg = val;
				clear_image();
			end
		endfunction

		function void add_pixel(bit p);
			int unsigned nr, nc, i, j;
			bit          final_row, end_row;
			out_item_t   beat;
			nr = clamp_dim(rows_reg);
			nc = clamp_dim(cols_reg);
			if (row_pos >= nr || col_pos >= nc)
				clear_image();
			i = row_pos;
			j = col_pos;
			final_row = (i + 1 == nr);
			end_row = (j + 1 == nc);

			// Bottom-right corner of a 2x2 block of ones: erosion hit, mark the four pixels.
			if (i >= 1 && j >= 1 && prev_pix[j-1] && prev_pix[j] && left_pix && p) begin
				prev_cov[j-1] = 1'b1;
				prev_cov[j] = 1'b1;
				cur_cov[j-1] = 1'b1;
				cur_cov[j] = 1'b1;
				if (squares < COUNT_MAX)
					squares++;
				beat = '0;
				beat.kind = KIND_SQUARE;
				beat.row = POS_W'(i);
				beat.col = POS_W'(j);
				queue_result(beat);
			end

			if (j >= 1)
				retire_col(j - 1, left_pix, i >= 1, final_row);
			if (end_row)
				retire_col(j, p, i >= 1, final_row);

			// Advance the position; the verdict closes the image.
			left_pix = p;
			if (end_row) begin
				col_pos = 0;
				left_pix = 1'b0;
				row_pos = i + 1;
				if (final_row) begin
					beat = '0;
					beat.kind = KIND_VERDICT;
					beat.fits = !mismatch;
					beat.count = CNT_W'(squares);
					beat.last = 1'b1;
					queue_result(beat);
					clear_image();
				end
			end else begin
				col_pos = j + 1;
			end
		endfunction

		function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, got kind %0d row %0d col %0d",
					$time, got.kind, got.row, got.col);
				return;
			end
			want = awaited_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("square_row", want.row, got.row);
			compare_field("square_col", want.col, got.col);
			compare_field("fits", want.fits, got.fits);
			compare_field("square_count", want.count, got.count);
			compare_field("last", want.last, got.last);
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	square_cover_tracker tracker;
	bit                  image_bits [MAX_DIM][MAX_DIM];
	bit                  sender_gaps;
	bit                  receiver_stalls;
	bit                  quiet;
	int unsigned         ready_hold;

	binary_grid_square_cover_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 4 ns clock.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Observe every handshake at the rising edge and feed the tracker.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				tracker.add_pixel(s_tdata[0]);
			if (m_tvalid && m_tready)
				tracker.check_beat({m_tuser, m_tdata[5:0], m_tdata[11:6], m_tdata[12],
					m_tdata[24:13], m_tlast});
		end
	end

	// Receiver: ready in random stretches, with stalls of random length when enabled.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (ready_hold != 0) begin
			ready_hold = ready_hold - 1;
		end else if (!receiver_stalls || quiet) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 9);
		end else begin
			m_tready <= 1'b1;
			ready_hold = $urandom_range(0, 15);
		end
	end

	// Hand one pixel beat to the block, possibly after a gap.
	task automatic send_pixel(bit p);
		int unsigned gap;
		if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, p};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every expected result has left the block.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Fill the image store; unflipped square-built images are exactly coverable.
	function automatic void build_image(int unsigned nr, int unsigned nc, image_style_t style);
		int unsigned n, r, c, density;
		for (r = 0; r < nr; r++)
			for (c = 0; c < nc; c++)
				image_bits[r][c] = (style == IMG_FULL);
		density = $urandom_range(1, 99);
		case (style)
			IMG_SQUARES, IMG_SQUARES_FLIP: begin
				n = $urandom_range(0, (nr * nc) / 3);
				repeat (n) begin
					r = $urandom_range(0, nr - 2);
					c = $urandom_range(0, nc - 2);
					image_bits[r][c] = 1'b1;
					image_bits[r][c+1] = 1'b1;
					image_bits[r+1][c] = 1'b1;
					image_bits[r+1][c+1] = 1'b1;
				end
				if (style == IMG_SQUARES_FLIP) begin
					r = $urandom_range(0, nr - 1);
					c = $urandom_range(0, nc - 1);
					image_bits[r][c] = !image_bits[r][c];
				end
			end
			IMG_NOISE: begin
				for (r = 0; r < nr; r++)
					for (c = 0; c < nc; c++)
						image_bits[r][c] = ($urandom_range(0, 99) < density);
			end
			default: ;
		endcase
	endfunction

	// Send the first take pixels of the stored image in row-major order.
	task automatic send_image(int unsigned nc, int unsigned take);
		int unsigned k;
		for (k = 0; k < take; k++)
			send_pixel(image_bits[k / nc][k % nc]);
	endtask

	// Dimension value to write: sometimes an out-of-range code that clamps to the same size.
	function automatic logic [DIM_W-1:0] encode_dim(int unsigned d);
		if (d == 2 && $urandom_range(0, 2) == 0)
			return DIM_W'($urandom_range(0, 1));
		if (d == MAX_DIM && $urandom_range(0, 1) == 0)
			return DIM_W'($urandom_range(MAX_DIM + 1, 127));
		return DIM_W'(d);
	endfunction

	initial begin
		int unsigned  nr, nc, take, shape, pick, random_sent, waited;
		bit           new_dims;
		image_style_t style;

		tracker = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		ready_hold = 0;
		quiet = 1'b0;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset dimensions: two full rows reach the highest column position;
		// the register write that follows abandons the rest of the image.
		build_image(MAX_DIM, MAX_DIM, IMG_FULL);
		send_image(MAX_DIM, MAX_DIM * 2);

		// Tall strip: an oversized row code clamps to 64, a column code of one to 2.
		write_cfg(REG_ROWS, 7'd127);
		write_cfg(REG_COLS, 7'd1);
		build_image(MAX_DIM, 2, IMG_FULL);
		send_image(2, MAX_DIM * 2);

		// Smallest image: one square, a lone uncovered corner, and a blank image.
		write_cfg(REG_ROWS, 7'd0);
		write_cfg(REG_COLS, 7'd1);
		repeat (4) send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		repeat (4) send_pixel(1'b0);

		// A column write in the middle of an image abandons it.
		write_cfg(REG_ROWS, 7'd3);
		write_cfg(REG_COLS, 7'd3);
		repeat (2) send_pixel(1'b1);
		write_cfg(REG_COLS, 7'd2);
		repeat (3) send_pixel(1'b1);

		// Writes to unused indexes leave the image in progress alone.
		write_cfg(REG_SPARE_A, '0);
		write_cfg(REG_SPARE_B, '1);
		repeat (3) send_pixel(1'b1);

		// Random images: mostly exactly coverable, some with a flipped pixel or noise.
		random_sent = 0;
		new_dims = 1'b1;
		nr = 3;
		nc = 2;
		while (random_sent < 550) begin
			if (random_sent >= 480)
				quiet = 1'b1;
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;

			if (new_dims || $urandom_range(0, 9) < 6) begin
				shape = $urandom_range(0, 19);
				if (shape == 0) begin
					nr = $urandom_range(2, 3);
					nc = $urandom_range(33, MAX_DIM);
				end else if (shape == 1) begin
					nr = $urandom_range(33, MAX_DIM);
					nc = $urandom_range(2, 3);
				end else if (shape < 5) begin
					nr = $urandom_range(2, 16);
					nc = $urandom_range(2, 16);
				end else begin
					nr = $urandom_range(2, 8);
					nc = $urandom_range(2, 8);
				end
				if ($urandom_range(0, 1) == 0) begin
					write_cfg(REG_ROWS, encode_dim(nr));
					write_cfg(REG_COLS, encode_dim(nc));
				end else begin
					write_cfg(REG_COLS, encode_dim(nc));
					write_cfg(REG_ROWS, encode_dim(nr));
				end
			end

			pick = $urandom_range(0, 9);
			if (pick < 5)
				style = IMG_SQUARES;
			else if (pick < 7)
				style = IMG_SQUARES_FLIP;
			else if (pick < 9)
				style = IMG_NOISE;
			else if ($urandom_range(0, 1) == 0)
				style = IMG_BLANK;
			else
				style = IMG_FULL;
			build_image(nr, nc, style);

			// Now and then cut the image short; the next register write abandons it.
			take = nr * nc;
			new_dims = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				take = $urandom_range(1, nr * nc - 1);
				new_dims = 1'b1;
			end
			send_image(nc, take);
			random_sent += take;
		end

		// Let the last results arrive, then let the block run on idle before the final check.
		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (tracker.pending() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (tracker.pending() != 0)
			$display("%0t: %0d expected result beats never arrived", $time, tracker.pending());

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
